### rtl/url_percent_codec_macros.svh
// Assertion macros shared by the URL percent codec RTL.
// No dependencies; included by the modules that carry checks.
`ifndef URL_PERCENT_CODEC_MACROS_SVH
`define URL_PERCENT_CODEC_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define UPC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("upc invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define UPC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("upc implication violated");

`endif

### rtl/upc_pkg.sv
// Shared types, character constants and helper functions for the URL percent codec.
// No dependencies; used by every module of the codec.
`default_nettype none

package upc_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_USCORE  = 8'h5f;
   localparam logic [7:0] CHAR_DASH    = 8'h2d;
   localparam logic [7:0] CHAR_STAR    = 8'h2a;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] UPPER_BASE   = CHAR_UPPER_A - 8'd10;
   localparam logic [7:0] LOWER_BASE   = CHAR_LOWER_A - 8'd10;
   localparam logic [3:0] NIBBLE_MASK  = 4'hf;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_FIRST,
      ESC_SECOND
   } esc_phase_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_HIGH,
      BACK_LOW
   } back_state_type;

   typedef enum logic {
      CMD_PLAIN,
      CMD_ESCAPE
   } cmd_kind_type;

   // One queued unit of work: a single result byte or a three-byte escape.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic         bad;
   } cmd_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] diff;
      if (c >= CHAR_LOWER_A) begin
         diff = c - LOWER_BASE;
      end else if (c >= CHAR_UPPER_A) begin
         diff = c - UPPER_BASE;
      end else begin
         diff = c - CHAR_ZERO;
      end
      return diff[3:0] & NIBBLE_MASK;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 4'd10) begin
         return CHAR_ZERO + {4'd0, n};
      end
      return UPPER_BASE + {4'd0, n};
   endfunction

   function automatic logic passes_plain(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_ZERO && c <= CHAR_NINE) ||
             c == CHAR_USCORE || c == CHAR_DASH || c == CHAR_STAR || c == CHAR_DOT;
   endfunction

endpackage

`default_nettype wire

### rtl/upc_front.sv
// Front end: accepts input bytes, tracks escape/drop state, classifies each byte into a command.
// Depends on upc_pkg.
`default_nettype none

module upc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_write_enable,
   input  wire logic            csr_write_data,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [7:0]      req_in_byte,
   input  wire logic            req_in_last,
   input  wire logic            queue_full,
   output logic                 push_valid,
   output upc_pkg::cmd_type     push_cmd
);

   logic                   direction_ff, direction_in;
   upc_pkg::esc_phase_type esc_ff, esc_in;
   logic [3:0]             high_ff, high_in;
   logic                   dropping_ff, dropping_in;

   logic                   accept;
   logic                   dec_error;
   logic                   dec_emit;
   logic [7:0]             dec_byte;
   upc_pkg::esc_phase_type dec_next;
   logic                   byte_is_hex;
   logic [3:0]             byte_nibble;

   assign req_ready   = !queue_full;
   assign accept      = req_valid && req_ready;
   assign byte_is_hex = upc_pkg::is_hex(req_in_byte);
   assign byte_nibble = upc_pkg::hex_nibble(req_in_byte);

   // decode classification of the byte on the input
   always_comb begin
      dec_error = 1'b0;
      dec_emit  = 1'b0;
      dec_byte  = req_in_byte;
      dec_next  = upc_pkg::ESC_NONE;
      unique case (esc_ff)
         upc_pkg::ESC_NONE: begin
            if (req_in_byte == upc_pkg::CHAR_PERCENT) begin
               if (req_in_last) begin
                  dec_error = 1'b1;
               end else begin
                  dec_next = upc_pkg::ESC_FIRST;
               end
            end else begin
               dec_emit = 1'b1;
               if (req_in_byte == upc_pkg::CHAR_PLUS) begin
                  dec_byte = upc_pkg::CHAR_SPACE;
               end
            end
         end
         upc_pkg::ESC_FIRST: begin
            if (!byte_is_hex || req_in_last) begin
               dec_error = 1'b1;
            end else begin
               dec_next = upc_pkg::ESC_SECOND;
            end
         end
         upc_pkg::ESC_SECOND: begin
            if (!byte_is_hex) begin
               dec_error = 1'b1;
            end else begin
               dec_emit = 1'b1;
               dec_byte = {high_ff, byte_nibble};
            end
         end
         default: begin
            dec_next = upc_pkg::ESC_NONE;
         end
      endcase
      if (dropping_ff) begin
         dec_error = 1'b1;
         dec_emit  = 1'b0;
         dec_next  = upc_pkg::ESC_NONE;
      end
   end

   // next state
   always_comb begin
      direction_in = direction_ff;
      esc_in       = esc_ff;
      high_in      = high_ff;
      dropping_in  = dropping_ff;
      if (csr_write_enable) begin
         direction_in = csr_write_data;
         esc_in       = upc_pkg::ESC_NONE;
         high_in      = 4'd0;
         dropping_in  = 1'b0;
      end else if (accept) begin
         if (direction_ff || req_in_last) begin
            esc_in      = upc_pkg::ESC_NONE;
            high_in     = 4'd0;
            dropping_in = 1'b0;
         end else if (dec_error) begin
            esc_in      = upc_pkg::ESC_NONE;
            high_in     = 4'd0;
            dropping_in = 1'b1;
         end else begin
            esc_in  = dec_next;
            high_in = (dec_next == upc_pkg::ESC_SECOND) ? byte_nibble : 4'd0;
         end
      end
   end

   // command to the queue
   always_comb begin
      push_cmd.kind = upc_pkg::CMD_PLAIN;
      push_cmd.data = req_in_byte;
      push_cmd.last = req_in_last;
      push_cmd.bad  = 1'b0;
      push_valid    = 1'b0;
      if (accept) begin
         if (direction_ff) begin
            push_valid = 1'b1;
            if (req_in_byte == upc_pkg::CHAR_SPACE) begin
               push_cmd.data = upc_pkg::CHAR_PLUS;
            end else if (!upc_pkg::passes_plain(req_in_byte)) begin
               push_cmd.kind = upc_pkg::CMD_ESCAPE;
            end
         end else if (dec_error && req_in_last) begin
            push_valid    = 1'b1;
            push_cmd.data = 8'd0;
            push_cmd.bad  = 1'b1;
         end else if (dec_emit) begin
            push_valid    = 1'b1;
            push_cmd.data = dec_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         esc_ff       <= upc_pkg::ESC_NONE;
         high_ff      <= 4'd0;
         dropping_ff  <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         esc_ff       <= esc_in;
         high_ff      <= high_in;
         dropping_ff  <= dropping_in;
      end
   end

endmodule

`default_nettype wire

### rtl/upc_queue.sv
// Short command queue between the codec front end and back end.
// Depends on upc_pkg and url_percent_codec_macros.svh.
`default_nettype none

`include "url_percent_codec_macros.svh"

module upc_queue #(
   parameter int Depth = upc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire upc_pkg::cmd_type  push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output upc_pkg::cmd_type       pop_cmd,
   output logic                   empty
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(Depth);

   upc_pkg::cmd_type        entries_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign full    = (count_ff == CountFull);
   assign empty   = (count_ff == '0);
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `UPC_ASSERT_IMPLIES(a_no_overflow, clock, reset, full, !push_valid)
   `UPC_ASSERT_IMPLIES(a_no_underflow, clock, reset, empty, !pop)

endmodule

`default_nettype wire

### rtl/upc_back.sv
// Back end: expands queued commands into result bytes behind a registered output stage.
// Depends on upc_pkg and url_percent_codec_macros.svh.
`default_nettype none

`include "url_percent_codec_macros.svh"

module upc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              queue_empty,
   input  wire upc_pkg::cmd_type  queue_cmd,
   output logic                   queue_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last,
   output logic                   rsp_bad_input
);

   upc_pkg::back_state_type state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_bad_ff, rsp_bad_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_last_ff, held_last_in;
   logic       out_free;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_bad_input = rsp_bad_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      if (out_free) begin
         unique case (state_ff)
            upc_pkg::BACK_IDLE: begin
               if (!queue_empty && queue_cmd.kind == upc_pkg::CMD_ESCAPE) begin
                  state_in = upc_pkg::BACK_HIGH;
               end
            end
            upc_pkg::BACK_HIGH: state_in = upc_pkg::BACK_LOW;
            upc_pkg::BACK_LOW:  state_in = upc_pkg::BACK_IDLE;
            default:            state_in = upc_pkg::BACK_IDLE;
         endcase
      end
   end

   // outputs
   always_comb begin
      queue_pop    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      held_byte_in = held_byte_ff;
      held_last_in = held_last_ff;
      if (out_free) begin
         unique case (state_ff)
            upc_pkg::BACK_IDLE: begin
               if (!queue_empty) begin
                  queue_pop    = 1'b1;
                  rsp_valid_in = 1'b1;
                  if (queue_cmd.kind == upc_pkg::CMD_ESCAPE) begin
                     rsp_byte_in  = upc_pkg::CHAR_PERCENT;
                     rsp_last_in  = 1'b0;
                     rsp_bad_in   = 1'b0;
                     held_byte_in = queue_cmd.data;
                     held_last_in = queue_cmd.last;
                  end else begin
                     rsp_byte_in = queue_cmd.data;
                     rsp_last_in = queue_cmd.last;
                     rsp_bad_in  = queue_cmd.bad;
                  end
               end
            end
            upc_pkg::BACK_HIGH: begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = upc_pkg::hex_digit(held_byte_ff[7:4]);
               rsp_last_in  = 1'b0;
               rsp_bad_in   = 1'b0;
            end
            upc_pkg::BACK_LOW: begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = upc_pkg::hex_digit(held_byte_ff[3:0]);
               rsp_last_in  = held_last_ff;
               rsp_bad_in   = 1'b0;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
      held_byte_ff <= held_byte_in;
      held_last_ff <= held_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= upc_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // mid-escape the output stage always holds a digit or the '%'
   `UPC_ASSERT_IMPLIES(a_escape_holds_output, clock, reset, state_ff != upc_pkg::BACK_IDLE, rsp_valid_ff)
   `UPC_ASSERT_IMPLIES(a_escape_not_last, clock, reset, rsp_valid_ff && state_ff == upc_pkg::BACK_LOW, !rsp_last_ff)
   `UPC_ASSERT_IMPLIES(a_error_result_form, clock, reset, rsp_valid_ff && rsp_bad_ff, rsp_last_ff && rsp_byte_ff == 8'd0)

endmodule

`default_nettype wire

### rtl/url_percent_codec.sv
// URL percent codec, one byte per transfer on each side.
// req_*: input bytes (req_in_byte, req_in_last) with valid/ready.
// rsp_*: result bytes (rsp_out_byte, rsp_out_last, rsp_bad_input) with valid/ready.
// csr_write_enable/csr_write_data: direction, 1 encodes, 0 decodes; write only when idle.
// Path: an input transfer is written into the queue, then the back end moves it into the
// output register that drives rsp_*; a full queue or a stalled output can hold it.
// Throughput: one byte per cycle while the queue has room; an encoded escape ('%' plus two
// hex digits) holds the output register for its three bytes; the queue of QUEUE_DEPTH
// commands between classifying front end and expanding back end fills and stalls req_ready.
// Decode errors (bad hex digit, escape cut by the last byte) drop the rest of the string
// and give one result with rsp_bad_input set on the byte marked last.
// Reset (synchronous) empties the queue and output stage, selects decoding and clears
// the escape state. If the receiver holds rsp_ready low the output register holds its
// result, the queue fills and req_ready falls; nothing is lost.
// Depends on upc_pkg, upc_front, upc_queue and upc_back.
`default_nettype none

module url_percent_codec #(
   parameter int QUEUE_DEPTH = upc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last,
   output logic            rsp_bad_input
);

   logic             queue_full;
   logic             queue_empty;
   logic             push_valid;
   upc_pkg::cmd_type push_cmd;
   logic             queue_pop;
   upc_pkg::cmd_type queue_cmd;

   upc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd)
   );

   upc_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_cmd    (queue_cmd),
      .empty      (queue_empty)
   );

   upc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .queue_cmd     (queue_cmd),
      .queue_pop     (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .rsp_bad_input (rsp_bad_input)
   );

endmodule

`default_nettype wire
